// ----- rtl/core/cvs_pkg.sv -----
// Package for the compact value serializer.
// Holds the channel payload types, the internal job type and format codes.
// No dependencies.
package cvs_pkg;

    localparam int JobBytes = 9;
    localparam int JobWordW = 8 * JobBytes;
    localparam int JobCntW  = 4;

    localparam logic [1:0] KIND_DECIMAL = 2'd0;
    localparam logic [1:0] KIND_BLOBLEN = 2'd1;
    localparam logic [1:0] KIND_BLOBBYTE = 2'd2;
    localparam logic [1:0] KIND_FIXED   = 2'd3;

    localparam logic [7:0] TAG_ZERO  = 8'd0;
    localparam logic [7:0] TAG_SIZE1 = 8'd1;
    localparam logic [7:0] TAG_SIZE2 = 8'd2;
    localparam logic [7:0] TAG_SIZE4 = 8'd4;
    localparam logic [7:0] TAG_SIZE8 = 8'd8;

    localparam logic [7:0]  HDR_LEN16 = 8'd255;
    localparam logic [7:0]  HDR_LEN32 = 8'd254;
    localparam logic [31:0] LEN_SHORT_LIMIT = 32'd253;
    localparam logic [31:0] LEN16_MAX = 32'd65535;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [63:0] value;
        logic [31:0]        length;
        logic [7:0]         data_byte;
        logic [3:0]         width_bytes;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic [31:0] total_bytes;
    } t_out_item;

    // Bytes of one item, left aligned (first byte in the top octet), and their count.
    typedef struct packed {
        logic [JobWordW-1:0] word;
        logic [JobCntW-1:0]  nbytes;
    } t_job;

endpackage

// ----- rtl/core/compact_value_serializer.sv -----
// Top level of the compact value serializer: classifier, job queue, serializer.
// Depends on cvs_pkg, cvs_front, cvs_queue and cvs_back.
//
//   Channel | Direction | Handshake          | Payload
//   input   | in        | i_valid / o_stall  | i_item (cvs_pkg::t_in_item)
//   output  | out       | o_valid / i_stall  | o_item (cvs_pkg::t_out_item)
//
// One output byte per cycle from the serializer while the receiver does not stall;
// an item produces 1 to 9 bytes, shifted out of the job word a byte at a time.
// When the serializer is idle, a job leaves the queue in the cycle after it was pushed.
// Synchronous active-low reset clears queue, byte count and output valid.
// Input stalls only while the queue of QUEUE_DEPTH jobs is full.
module compact_value_serializer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  cvs_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output cvs_pkg::t_out_item o_item
);

    cvs_pkg::t_job front_job;
    cvs_pkg::t_job queue_job;
    logic          queue_full;
    logic          queue_nonempty;
    logic          queue_pop;
    logic          queue_push;

    assign o_stall    = queue_full;
    assign queue_push = i_valid && !queue_full;

    cvs_front u_front (
        .i_item (i_item),
        .o_job  (front_job)
    );

    cvs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (queue_push),
        .i_job      (front_job),
        .o_full     (queue_full),
        .i_pop      (queue_pop),
        .o_nonempty (queue_nonempty),
        .o_job      (queue_job)
    );

    cvs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_nonempty),
        .i_job       (queue_job),
        .o_job_pop   (queue_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

// ----- rtl/core/cvs_front.sv -----
// Front end: classifies an input item into a left-aligned byte job.
// Depends on cvs_pkg.
module cvs_front (
    input  cvs_pkg::t_in_item i_item,
    output cvs_pkg::t_job     o_job
);

    logic        fits8;
    logic        fits16;
    logic        fits32;
    logic [3:0]  width;
    logic [2:0]  pad;
    logic [63:0] fixed_word;

    always_comb begin
        fits8  = (i_item.value[63:7] == '0) || (i_item.value[63:7] == '1);
        fits16 = (i_item.value[63:15] == '0) || (i_item.value[63:15] == '1);
        fits32 = (i_item.value[63:31] == '0) || (i_item.value[63:31] == '1);

        // clamp width into 1..8
        if (i_item.width_bytes == 4'd0) begin
            width = 4'd1;
        end else if (i_item.width_bytes > 4'd8) begin
            width = 4'd8;
        end else begin
            width = i_item.width_bytes;
        end
        pad        = 3'(4'd8 - width);
        fixed_word = i_item.value << {pad, 3'b000};
    end

    always_comb begin
        o_job = '0;
        case (i_item.kind)
            cvs_pkg::KIND_DECIMAL: begin
                if (i_item.value == '0) begin
                    o_job.word   = {cvs_pkg::TAG_ZERO, 64'd0};
                    o_job.nbytes = 4'd1;
                end else if (fits8) begin
                    o_job.word   = {cvs_pkg::TAG_SIZE1, i_item.value[7:0], 56'd0};
                    o_job.nbytes = 4'd2;
                end else if (fits16) begin
                    o_job.word   = {cvs_pkg::TAG_SIZE2, i_item.value[15:0], 48'd0};
                    o_job.nbytes = 4'd3;
                end else if (fits32) begin
                    o_job.word   = {cvs_pkg::TAG_SIZE4, i_item.value[31:0], 32'd0};
                    o_job.nbytes = 4'd5;
                end else begin
                    o_job.word   = {cvs_pkg::TAG_SIZE8, i_item.value};
                    o_job.nbytes = 4'd9;
                end
            end
            cvs_pkg::KIND_BLOBLEN: begin
                if (i_item.length < cvs_pkg::LEN_SHORT_LIMIT) begin
                    // zero length falls in here and emits a single zero byte
                    o_job.word   = {i_item.length[7:0], 64'd0};
                    o_job.nbytes = 4'd1;
                end else if (i_item.length <= cvs_pkg::LEN16_MAX) begin
                    o_job.word   = {cvs_pkg::HDR_LEN16, i_item.length[15:0], 48'd0};
                    o_job.nbytes = 4'd3;
                end else begin
                    o_job.word   = {cvs_pkg::HDR_LEN32, i_item.length, 32'd0};
                    o_job.nbytes = 4'd5;
                end
            end
            cvs_pkg::KIND_BLOBBYTE: begin
                o_job.word   = {i_item.data_byte, 64'd0};
                o_job.nbytes = 4'd1;
            end
            cvs_pkg::KIND_FIXED: begin
                o_job.word   = {fixed_word, 8'd0};
                o_job.nbytes = width;
            end
            default: begin
                o_job = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/cvs_queue.sv -----
// Small job queue between the classifier and the byte serializer.
// Depends on cvs_pkg.
module cvs_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cvs_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output cvs_pkg::t_job o_job
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    cvs_pkg::t_job   r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_full     = (r_count == CntW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- rtl/core/cvs_back.sv -----
// Back end: shifts each job out one byte per beat and keeps the running count.
// Depends on cvs_pkg.
module cvs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  cvs_pkg::t_job     i_job,
    output logic              o_job_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output cvs_pkg::t_out_item o_item
);

    localparam int WordW = cvs_pkg::JobWordW;

    logic [WordW-1:0]            r_word, n_word;
    logic [cvs_pkg::JobCntW-1:0] r_left, n_left;
    logic [31:0]                 r_count, n_count;
    logic                        r_valid, n_valid;
    cvs_pkg::t_out_item          r_item, n_item;
    logic                        out_free;
    logic                        emit;

    assign out_free  = !r_valid || !i_stall;
    assign emit      = out_free && (r_left != '0);
    // refill as the last byte goes out so items run without a gap
    assign o_job_pop = i_job_valid && ((r_left == '0) || (emit && r_left == 4'd1));
    assign o_valid   = r_valid;
    assign o_item    = r_item;

    always_comb begin
        n_word  = r_word;
        n_left  = r_left;
        n_count = r_count;
        n_valid = r_valid;
        n_item  = r_item;
        if (emit) begin
            n_count            = r_count + 32'd1;
            n_item.out_byte    = r_word[WordW-1 -: 8];
            n_item.last        = (r_left == 4'd1);
            n_item.total_bytes = n_count;
            n_valid            = 1'b1;
            n_word             = {r_word[WordW-9:0], 8'd0};
            n_left             = r_left - 1'b1;
        end else if (out_free) begin
            n_valid = 1'b0;
        end
        if (o_job_pop) begin
            n_word = i_job.word;
            n_left = i_job.nbytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_left  <= n_left;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_item <= n_item;
    end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for compact_value_serializer: directed and random items,
// a byte-level predictor, and a checker on the output channel.
// Depends on cvs_pkg and the compact_value_serializer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    cvs_pkg::t_in_item  i_item  = '0;
    logic               o_stall;
    logic               o_valid;
    cvs_pkg::t_out_item o_item;

    cvs_pkg::t_out_item pending_bytes[$];
    logic [31:0]        bytes_emitted = '0;
    int                 mismatch_count = 0;
    int                 src_gap_pct = 0;
    int                 sink_stall_pct = 0;
    int                 hold_cycles_req = 0;
    int                 hold_left = 0;

    compact_value_serializer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always #5 i_clk = ~i_clk;

    // Work out the bytes of one accepted item, left aligned in a 72-bit word.
    function automatic void predict_bytes(input cvs_pkg::t_in_item it);
        logic [71:0] word;
        logic [63:0] v;
        longint      sv;
        int          n;
        int          w;
        v  = it.value;
        sv = it.value;
        word = '0;
        n = 1;
        case (it.kind)
            cvs_pkg::KIND_DECIMAL: begin
                if (sv == 0) begin
                    word = {cvs_pkg::TAG_ZERO, 64'h0};
                end else if (sv >= -128 && sv <= 127) begin
                    word = {cvs_pkg::TAG_SIZE1, v << 56};
                    n = 2;
                end else if (sv >= -32768 && sv <= 32767) begin
                    word = {cvs_pkg::TAG_SIZE2, v << 48};
                    n = 3;
                end else if (sv >= -64'sd2147483648 && sv <= 64'sd2147483647) begin
                    word = {cvs_pkg::TAG_SIZE4, v << 32};
                    n = 5;
                end else begin
                    word = {cvs_pkg::TAG_SIZE8, v};
                    n = 9;
                end
            end
            cvs_pkg::KIND_BLOBLEN: begin
                if (it.length < cvs_pkg::LEN_SHORT_LIMIT) begin
                    word = {it.length[7:0], 64'h0};
                end else if (it.length <= cvs_pkg::LEN16_MAX) begin
                    word = {cvs_pkg::HDR_LEN16, it.length[15:0], 48'h0};
                    n = 3;
                end else begin
                    word = {cvs_pkg::HDR_LEN32, it.length, 32'h0};
                    n = 5;
                end
            end
            cvs_pkg::KIND_BLOBBYTE: begin
                word = {it.data_byte, 64'h0};
            end
            default: begin
                // clamp odd widths: zero acts as one, above eight as eight
                w = (it.width_bytes == 0) ? 1 : (it.width_bytes > 8) ? 8 : int'(it.width_bytes);
                word = {v << (64 - 8 * w), 8'h0};
                n = w;
            end
        endcase
        for (int i = 0; i < n; i++) begin
            cvs_pkg::t_out_item b;
            bytes_emitted = bytes_emitted + 1;
            b.out_byte    = word[71 - 8 * i -: 8];
            b.last        = (i == n - 1);
            b.total_bytes = bytes_emitted;
            pending_bytes.push_back(b);
        end
    endfunction

    function automatic cvs_pkg::t_in_item make_item(input logic [1:0] kind,
                                                    input logic [63:0] value,
                                                    input logic [31:0] length,
                                                    input logic [7:0] data,
                                                    input logic [3:0] width);
        cvs_pkg::t_in_item it;
        it.kind        = kind;
        it.value       = value;
        it.length      = length;
        it.data_byte   = data;
        it.width_bytes = width;
        return it;
    endfunction

    function automatic cvs_pkg::t_in_item rand_item();
        cvs_pkg::t_in_item it;
        logic [63:0]       raw;
        logic [63:0]       value_corners[10];
        logic [31:0]       len_corners[6];
        value_corners = '{64'h0, 64'h7f, 64'hffff_ffff_ffff_ff80, 64'h80,
                          64'hffff_ffff_ffff_7fff, 64'h8000, 64'h7fff_ffff,
                          64'hffff_ffff_8000_0000, 64'h8000_0000_0000_0000,
                          64'h7fff_ffff_ffff_ffff};
        len_corners = '{32'd0, 32'd252, 32'd253, 32'd65535, 32'd65536, 32'hffff_ffff};
        raw = {$urandom, $urandom};
        it.kind      = 2'($urandom_range(0, 3));
        it.data_byte = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            it.width_bytes = 4'($urandom);
        else
            it.width_bytes = 4'd1 << $urandom_range(0, 3);
        case ($urandom_range(0, 5))
            0: it.value = value_corners[$urandom_range(0, 9)];
            1: it.value = {{56{raw[7]}}, raw[7:0]};
            2: it.value = {{48{raw[15]}}, raw[15:0]};
            3: it.value = {{32{raw[31]}}, raw[31:0]};
            default: it.value = raw;
        endcase
        case ($urandom_range(0, 3))
            0: it.length = $urandom_range(0, 252);
            1: it.length = $urandom_range(253, 65535);
            2: it.length = $urandom;
            default: it.length = len_corners[$urandom_range(0, 5)];
        endcase
        return it;
    endfunction

    // Offer one beat, holding it until accepted; idle first at the sender's rate.
    task automatic send_item(input cvs_pkg::t_in_item it);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_bytes(it);
    endtask

    // Receiver stall: a requested hold-off wins, otherwise stall at random.
    always @(posedge i_clk) begin
        if (hold_cycles_req > 0) begin
            hold_left = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            cvs_pkg::t_out_item want;
            if (pending_bytes.size() == 0) begin
                $error("out_byte: expected none, got %0h", o_item.out_byte);
                mismatch_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_item.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, o_item.out_byte);
                    mismatch_count++;
                end
                if (o_item.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_item.last);
                    mismatch_count++;
                end
                if (o_item.total_bytes !== want.total_bytes) begin
                    $error("total_bytes: expected %0d, got %0d", want.total_bytes,
                           o_item.total_bytes);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_decimal_sizes();
        logic [63:0] vals[10];
        vals = '{64'h0, 64'h7f, 64'hffff_ffff_ffff_ff80, 64'h80, 64'hffff_ffff_ffff_7fff,
                 64'h7fff, 64'hffff_ffff_8000_0000, 64'h8000_0000,
                 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000};
        foreach (vals[i])
            send_item(make_item(cvs_pkg::KIND_DECIMAL, vals[i], '0, '0, '0));
    endtask

    task automatic test_blob_header();
        logic [31:0] lens[6];
        lens = '{32'd0, 32'd252, 32'd253, 32'd65535, 32'd65536, 32'hffff_ffff};
        foreach (lens[i])
            send_item(make_item(cvs_pkg::KIND_BLOBLEN, '0, lens[i], '0, '0));
        send_item(make_item(cvs_pkg::KIND_BLOBBYTE, '1, '1, 8'h00, '1));
        send_item(make_item(cvs_pkg::KIND_BLOBBYTE, '0, '0, 8'hff, '0));
    endtask

    task automatic test_fixed_widths();
        send_item(make_item(cvs_pkg::KIND_FIXED, 64'h0123_4567_89ab_cdef, '0, '0, 4'd0));
        send_item(make_item(cvs_pkg::KIND_FIXED, 64'h0123_4567_89ab_cdef, '0, '0, 4'd3));
        send_item(make_item(cvs_pkg::KIND_FIXED, 64'hffff_ffff_ffff_ffff, '0, '0, 4'd8));
        send_item(make_item(cvs_pkg::KIND_FIXED, 64'h8000_0000_0000_0001, '0, '0, 4'd15));
    endtask

    // Mostly single random items, now and then a blob header with its data bytes.
    task automatic test_random(input int count, input int gap_pct, input int stall_pct);
        int sent;
        int blob_len;
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 7) == 0) begin
                blob_len = $urandom_range(0, 4);
                send_item(make_item(cvs_pkg::KIND_BLOBLEN, {$urandom, $urandom}, blob_len,
                                    8'($urandom), 4'($urandom)));
                for (int i = 0; i < blob_len; i++)
                    send_item(make_item(cvs_pkg::KIND_BLOBBYTE, {$urandom, $urandom},
                                        $urandom, 8'($urandom), 4'($urandom)));
                sent += blob_len + 1;
            end else begin
                send_item(rand_item());
                sent++;
            end
        end
    endtask

    // Hold the receiver off while the sender keeps offering long items.
    task automatic test_backpressure();
        src_gap_pct     = 0;
        sink_stall_pct  = 0;
        hold_cycles_req = 300;
        for (int i = 0; i < 20; i++)
            send_item(make_item(cvs_pkg::KIND_DECIMAL, {1'b1, 63'($urandom)}, $urandom,
                                8'($urandom), 4'($urandom)));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_decimal_sizes();
        test_blob_header();
        test_fixed_widths();
        test_random(72, 0, 0);
        test_random(72, 75, 0);
        test_random(72, 0, 75);
        test_random(72, 7, 7);
        test_backpressure();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_bytes.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
